// ===== rtl/ptg_pkg.sv =====
// ----------------------------------------------------------------------------
// ptg_pkg
// shared constants for the square-wave tone generator: action codes,
// frequency limits, reset values and parameter defaults
// ----------------------------------------------------------------------------
`default_nettype none

package ptg_pkg;

    // field widths
    localparam int ACT_W  = 2;
    localparam int FREQ_W = 16;
    localparam int OUT_W  = 18;   // width of the reported counter value

    // action codes
    localparam logic [ACT_W-1:0] ACT_TICK     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TONE_ON  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TONE_OFF = 2'd2;

    // frequency clamp, divisor fits in DVS_W bits after clamping
    localparam logic [FREQ_W-1:0] FREQ_MIN = 16'd100;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 16'd10000;
    localparam int                DVS_W    = 14;

    localparam int PERIOD_MIN   = 2;
    localparam int RESET_RELOAD = 999;

    // parameter defaults
    localparam int CLOCK_HZ_DEF     = 16000000;
    localparam int COUNTER_BITS_DEF = 18;

endpackage : ptg_pkg

`default_nettype wire

// ===== rtl/pwm_tone_generator.sv =====
// ----------------------------------------------------------------------------
// pwm_tone_generator
// square-wave tone generator: up-counter with preloaded reload and compare
// values, tone period found by a bit-serial restoring divider
// ----------------------------------------------------------------------------
// usage
//   input channel  : i_in_valid / o_in_stall, payload i_action, i_frequency_hz
//   output channel : o_out_valid / i_out_stall, payload o_pwm_out,
//                    o_counter_value, o_tone_active
//   every accepted transaction produces exactly one result transaction
//   tick, tone-off and unused codes: result registered on acceptance, valid in
//     the next cycle; a new transaction can be taken every cycle as long as the
//     receiver drains results
//   tone-on: CLOCK_HZ / frequency is worked out one quotient bit per cycle
//     in S_DIV; the dividend is DIV_W = clog2(CLOCK_HZ+1) bits (24 at 16 MHz);
//     the result is registered in S_DONE once the output register is free,
//     and o_in_stall is high while the divider runs
//   reset (i_rst_n low, synchronous): counter 0, reload 999, compare 0,
//     divider idle, no result pending
//   receiver stall: the result stays in the output register unchanged; a
//     new transaction is only accepted when that register is free or being
//     drained in the same cycle, so nothing is lost or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_tone_generator #(
    parameter int CLOCK_HZ     = ptg_pkg::CLOCK_HZ_DEF,
    parameter int COUNTER_BITS = ptg_pkg::COUNTER_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [ptg_pkg::ACT_W-1:0]   i_action,
    input  wire logic [ptg_pkg::FREQ_W-1:0]  i_frequency_hz,
    // output channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic                             o_pwm_out,
    output logic [ptg_pkg::OUT_W-1:0]        o_counter_value,
    output logic                             o_tone_active
);
    import ptg_pkg::*;

    localparam int CB     = COUNTER_BITS;
    localparam int DIV_W  = $clog2(CLOCK_HZ + 1);           // dividend width
    localparam int PER_W  = (DIV_W > CB) ? DIV_W : CB + 1;  // period width
    localparam int STEP_W = $clog2(DIV_W + 1);
    localparam int REM_W  = DVS_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    // timer state
    logic [CB-1:0] r_counter;
    logic [CB-1:0] r_reload_pre;
    logic [CB-1:0] r_reload_act;
    logic [CB-1:0] r_cmp_pre;
    logic [CB-1:0] r_cmp_act;

    // bit-serial divider
    logic [DIV_W-1:0]  r_dvd;     // dividend, shifted out msb first
    logic [DIV_W-1:0]  r_quo;     // quotient, shifted in at the lsb, msb first
    logic [REM_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [STEP_W-1:0] r_step;

    // result register
    logic              r_out_valid;
    logic              r_pwm_out;
    logic [OUT_W-1:0]  r_counter_value;
    logic              r_tone_active;

    logic in_accept;
    logic out_free;

    // clamp of the requested frequency
    logic [FREQ_W-1:0] freq_clamp;

    // one restoring step
    logic [REM_W-1:0] trial;
    logic [REM_W:0]   diff;
    logic             q_bit;

    // period saturation and derived preload values
    logic [PER_W-1:0] per_raw;
    logic [PER_W-1:0] per_sat;
    logic [PER_W-1:0] per_m1;
    logic [CB-1:0]    new_reload;
    logic [CB-1:0]    new_cmp;

    // tick path
    logic          tick_wrap;
    logic [CB-1:0] tick_counter;
    logic [CB-1:0] tick_cmp;

    // next result values for tick, tone-off and unused codes
    logic [CB-1:0]       n_counter;
    logic [CB-1:0]       n_cmp_act;
    logic [CB+OUT_W-1:0] n_cnt_ext;
    logic [CB+OUT_W-1:0] cnt_zero_ext;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        if (i_frequency_hz < FREQ_MIN) begin
            freq_clamp = FREQ_MIN;
        end else if (i_frequency_hz > FREQ_MAX) begin
            freq_clamp = FREQ_MAX;
        end else begin
            freq_clamp = i_frequency_hz;
        end
    end

    // remainder is always below the divisor, so its top bit is free
    assign trial = {r_rem[REM_W-2:0], r_dvd[DIV_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_dvs};
    assign q_bit = !diff[REM_W];

    // period = quotient, kept within 2 .. 2^CB
    always_comb begin
        per_raw = PER_W'(r_quo);
        if (per_raw > (PER_W'(1) << CB)) begin
            per_sat = PER_W'(1) << CB;
        end else if (per_raw < PER_W'(PERIOD_MIN)) begin
            per_sat = PER_W'(PERIOD_MIN);
        end else begin
            per_sat = per_raw;
        end
        per_m1     = per_sat - PER_W'(1);
        new_reload = per_m1[CB-1:0];
        new_cmp    = per_sat[CB:1];
    end

    // tick: wrap at the active reload, loading the preloads
    assign tick_wrap    = (r_counter >= r_reload_act);
    assign tick_counter = tick_wrap ? '0 : r_counter + CB'(1);
    assign tick_cmp     = tick_wrap ? r_cmp_pre : r_cmp_act;

    always_comb begin
        if (i_action == ACT_TICK) begin
            n_counter = tick_counter;
            n_cmp_act = tick_cmp;
        end else begin
            n_counter = r_counter;
            n_cmp_act = r_cmp_act;
        end
    end

    // report the low OUT_W bits, zero-extended when the counter is narrower
    assign n_cnt_ext    = {{OUT_W{1'b0}}, n_counter};
    assign cnt_zero_ext = '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_counter    <= '0;
            r_reload_pre <= CB'(RESET_RELOAD);
            r_reload_act <= CB'(RESET_RELOAD);
            r_cmp_pre    <= '0;
            r_cmp_act    <= '0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_action == ACT_TONE_ON) begin
                            // start the division CLOCK_HZ / frequency
                            r_dvd   <= DIV_W'(CLOCK_HZ);
                            r_quo   <= '0;
                            r_rem   <= '0;
                            r_dvs   <= freq_clamp[DVS_W-1:0];
                            r_step  <= '0;
                            r_state <= S_DIV;
                        end else begin
                            if (i_action == ACT_TICK) begin
                                r_counter <= tick_counter;
                                if (tick_wrap) begin
                                    r_reload_act <= r_reload_pre;
                                    r_cmp_act    <= r_cmp_pre;
                                end
                            end else if (i_action == ACT_TONE_OFF) begin
                                r_cmp_pre <= '0;
                            end
                            r_out_valid     <= 1'b1;
                            r_pwm_out       <= (n_counter < n_cmp_act);
                            r_counter_value <= n_cnt_ext[OUT_W-1:0];
                            r_tone_active   <= (n_cmp_act != '0);
                        end
                    end
                end
                S_DIV: begin
                    r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
                    r_quo  <= {r_quo[DIV_W-2:0], q_bit};
                    r_rem  <= q_bit ? diff[REM_W-1:0] : trial;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // forced update event: restart and load the new values
                    if (out_free) begin
                        r_reload_pre    <= new_reload;
                        r_reload_act    <= new_reload;
                        r_cmp_pre       <= new_cmp;
                        r_cmp_act       <= new_cmp;
                        r_counter       <= '0;
                        r_out_valid     <= 1'b1;
                        r_pwm_out       <= (new_cmp != '0);
                        r_counter_value <= cnt_zero_ext[OUT_W-1:0];
                        r_tone_active   <= (new_cmp != '0);
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pwm_out       = r_pwm_out;
    assign o_counter_value = r_counter_value;
    assign o_tone_active   = r_tone_active;

endmodule : pwm_tone_generator

`default_nettype wire

// ===== rtl/ptg_checker.sv =====
// ----------------------------------------------------------------------------
// ptg_checker
// port-level checks for the tone generator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ptg_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic [ptg_pkg::ACT_W-1:0]   i_action,
    input wire logic [ptg_pkg::FREQ_W-1:0]  i_frequency_hz,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic                        o_pwm_out,
    input wire logic [ptg_pkg::OUT_W-1:0]   o_counter_value,
    input wire logic                        o_tone_active
);
    import ptg_pkg::*;

    logic in_acc;
    logic freq_used;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign freq_used = (i_frequency_hz != '0) || 1'b1;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_pwm_out) && $stable(o_counter_value)
             && $stable(o_tone_active)))
        else $error("stalled result changed");

    // output can only be high with a nonzero active compare
    a_pwm_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pwm_out) |-> o_tone_active)
        else $error("pwm high without active tone");

    // actions other than tone-on deliver their result in the next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action != ACT_TONE_ON)) |=> o_out_valid)
        else $error("missing result after tick or tone-off");

    // tone-on keeps the input stalled while the divider runs
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_TONE_ON) && freq_used) |=> o_in_stall)
        else $error("input accepted during division");

    // an inactive tone keeps the pwm output low
    a_tone_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tone_active) |-> !o_pwm_out)
        else $error("pwm high while tone inactive");

endmodule : ptg_checker

bind pwm_tone_generator ptg_checker u_ptg_checker (.*);

`default_nettype wire
